FILE: rtl/tgcs_pkg.sv
package tgcs_pkg;

  localparam int NUM_GATES = 8;
  localparam int END_W     = 11;
  localparam int SUM_W     = 26;
  localparam int SAMPLE_W  = 16;
  localparam int CFG_IDX_W = 3;

  typedef logic [NUM_GATES-1:0][END_W-1:0] end_array_t;
  typedef logic [NUM_GATES-1:0][SUM_W-1:0] sum_array_t;

  typedef struct packed {
    logic fire;
    logic last;
  } step_ctl_t;

  localparam end_array_t GATE_END_RESET = {
    11'd200, 11'd175, 11'd160, 11'd105, 11'd95, 11'd75, 11'd60, 11'd31
  };

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

endpackage

FILE: rtl/tgcs_cfg_regs.sv
module tgcs_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tgcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tgcs_pkg::END_W-1:0]       cfg_data,
  output tgcs_pkg::end_array_t             gate_end
);
  import tgcs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_end <= GATE_END_RESET;
    end else if (cfg_we) begin
      gate_end[cfg_index] <= cfg_data;
    end
  end

endmodule

FILE: rtl/tgcs_accum.sv
module tgcs_accum #(
  parameter int MAX_TRACE_SAMPLES = 1024,
  parameter int SAMPLE_BITS       = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tgcs_pkg::step_ctl_t              step,
  input  logic [tgcs_pkg::SAMPLE_W-1:0]    sample,
  input  tgcs_pkg::end_array_t             gate_end,
  output tgcs_pkg::sum_array_t             sums_upd
);
  import tgcs_pkg::*;

  localparam int IDX_W = $clog2(MAX_TRACE_SAMPLES + 1);
  localparam int CMP_W = (IDX_W > END_W) ? IDX_W : END_W;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  sum_array_t       acc;
  sum_array_t       acc_next;
  logic             in_range;
  logic [SUM_W:0]   smp_ext;

  assign in_range = (idx < IDX_W'(MAX_TRACE_SAMPLES));
  assign smp_ext  = (SUM_W+1)'(sample[SAMPLE_BITS-1:0]);

  // eight independent window compares and saturating adds
  always_comb begin
    logic [CMP_W-1:0] start_w;
    logic [CMP_W-1:0] stop_w;
    logic [CMP_W-1:0] idx_w;
    logic [SUM_W:0]   sum_w;
    idx_w = CMP_W'(idx);
    for (int k = 0; k < NUM_GATES; k++) begin
      start_w = (k == 0) ? '0 : CMP_W'(gate_end[(k == 0) ? 0 : k-1]);
      stop_w  = CMP_W'(gate_end[k]);
      sum_w   = {1'b0, acc[k]} + smp_ext;
      if (in_range && (idx_w >= start_w) && (idx_w < stop_w)) begin
        sums_upd[k] = sum_w[SUM_W] ? SUM_MAX : sum_w[SUM_W-1:0];
      end else begin
        sums_upd[k] = acc[k];
      end
    end
  end

  always_comb begin
    idx_next = idx;
    acc_next = acc;
    if (step.fire) begin
      if (step.last) begin
        idx_next = '0;
        acc_next = '0;
      end else begin
        acc_next = sums_upd;
        if (in_range) begin
          idx_next = idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      acc <= '0;
    end else begin
      idx <= idx_next;
      acc <= acc_next;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step.fire && step.last |=> (idx == '0) && (acc == '0))
    else $error("index or sums not cleared after last transaction");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    idx <= IDX_W'(MAX_TRACE_SAMPLES))
    else $error("sample index beyond trace bound");

endmodule

FILE: rtl/trace_gate_charge_sums_core.sv
// The result of a last sample transaction passes the input register, then the output
// register; a last sample waits in the input register while a result is unread.
// Throughput: one sample per cycle while no last sample waits on an unread result;
// the eight window compare-and-add updates run in parallel, and the output register
// lets the next trace start while a result waits. Reset (rst, synchronous) clears the
// running sums, index and both handshake stages, and loads the default gate ends.
module trace_gate_charge_sums_core #(
  parameter int MAX_TRACE_SAMPLES = 1024,
  parameter int SAMPLE_BITS       = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tgcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tgcs_pkg::END_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tgcs_pkg::SAMPLE_W-1:0]    sample,
  input  logic                             last_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tgcs_pkg::SUM_W-1:0]       sum0,
  output logic [tgcs_pkg::SUM_W-1:0]       sum1,
  output logic [tgcs_pkg::SUM_W-1:0]       sum2,
  output logic [tgcs_pkg::SUM_W-1:0]       sum3,
  output logic [tgcs_pkg::SUM_W-1:0]       sum4,
  output logic [tgcs_pkg::SUM_W-1:0]       sum5,
  output logic [tgcs_pkg::SUM_W-1:0]       sum6,
  output logic [tgcs_pkg::SUM_W-1:0]       sum7
);
  import tgcs_pkg::*;

  end_array_t           gate_end;
  sum_array_t           sums_upd;
  sum_array_t           sums;
  step_ctl_t            step;
  logic                 s1_valid;
  logic [SAMPLE_W-1:0]  s1_sample;
  logic                 s1_last;
  logic                 drain;

  tgcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gate_end  (gate_end)
  );

  tgcs_accum #(
    .MAX_TRACE_SAMPLES (MAX_TRACE_SAMPLES),
    .SAMPLE_BITS       (SAMPLE_BITS)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .sample   (s1_sample),
    .gate_end (gate_end),
    .sums_upd (sums_upd)
  );

  // a last sample only moves on when the output register is free
  assign drain     = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready  = !s1_valid || drain;
  assign step.fire = drain;
  assign step.last = s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (drain) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample <= sample;
      s1_last   <= last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain && s1_last) begin
      sums <= sums_upd;
    end
  end

  assign sum0 = sums[0];
  assign sum1 = sums[1];
  assign sum2 = sums[2];
  assign sum3 = sums[3];
  assign sum4 = sums[4];
  assign sum5 = sums[5];
  assign sum6 = sums[6];
  assign sum7 = sums[7];

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && s1_last && out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_last))
    else $error("result raised without a last transaction");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tgcs_pkg::*;

  localparam int TRACE_BOUND   = 1024;
  localparam int SAMPLE_BITS   = 16;
  localparam int PHASES        = 12;
  localparam int PHASE_SAMPLES = 70;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 4000;

  typedef enum logic [CFG_IDX_W-1:0] {
    GATE0_END, GATE1_END, GATE2_END, GATE3_END,
    GATE4_END, GATE5_END, GATE6_END, GATE7_END
  } gate_reg_e;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  class charge_sum_board;
    logic [END_W-1:0] gate_end [NUM_GATES];
    logic [END_W-1:0] sample_index;
    logic [SUM_W-1:0] window_sum [NUM_GATES];
    sum_array_t       pending_sums [$];
    int               errors;

    function new();
      errors = 0;
      sample_index = '0;
      for (int k = 0; k < NUM_GATES; k++) begin
        gate_end[k] = GATE_END_RESET[k];
        window_sum[k] = '0;
      end
    endfunction

    function void set_gate_end(int k, logic [END_W-1:0] value);
      gate_end[k] = value;
    endfunction

    function void integrate_sample(logic [SAMPLE_W-1:0] s, logic last);
      logic [END_W-1:0] lo;
      logic [SUM_W:0]   acc;
      logic [SAMPLE_W-1:0] smp;
      sum_array_t       sums;
      smp = s & SAMPLE_W'((1 << SAMPLE_BITS) - 1);
      lo = '0;
      if (sample_index < TRACE_BOUND) begin
        for (int k = 0; k < NUM_GATES; k++) begin
          if (sample_index >= lo && sample_index < gate_end[k]) begin
            acc = {1'b0, window_sum[k]} + (SUM_W + 1)'(smp);
            window_sum[k] = (acc > SUM_MAX) ? SUM_MAX : acc[SUM_W-1:0];
          end
          lo = gate_end[k];
        end
        sample_index = sample_index + 1'b1;
      end
      if (last) begin
        for (int k = 0; k < NUM_GATES; k++) begin
          sums[k] = window_sum[k];
          window_sum[k] = '0;
        end
        pending_sums.push_back(sums);
        sample_index = '0;
      end
    endfunction

    function void check_sums(sum_array_t got);
      sum_array_t want;
      if (pending_sums.size() == 0) begin
        $error("unexpected result transaction: sum0 %0d", got[0]);
        errors++;
        return;
      end
      want = pending_sums.pop_front();
      for (int k = 0; k < NUM_GATES; k++) begin
        if (got[k] !== want[k]) begin
          $error("sum%0d: expected %0d, actual %0d", k, want[k], got[k]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [END_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [SAMPLE_W-1:0]  sample;
  logic                 last_sample;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SUM_W-1:0]     sum0, sum1, sum2, sum3, sum4, sum5, sum6, sum7;

  charge_sum_board board;
  int              send_idle_pct;
  int              stall_pct;
  int              quiet_cycles;

  trace_gate_charge_sums_core #(
    .MAX_TRACE_SAMPLES(TRACE_BOUND),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .last_sample(last_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sum0(sum0),
    .sum1(sum1),
    .sum2(sum2),
    .sum3(sum3),
    .sum4(sum4),
    .sum5(sum5),
    .sum6(sum6),
    .sum7(sum7)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_sums({sum7, sum6, sum5, sum4, sum3, sum2, sum1, sum0});
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic end_array_t pick_ends(int kind);
    end_array_t e;
    int         acc;
    acc = 0;
    for (int k = 0; k < NUM_GATES; k++) begin
      case (kind)
        0: e[k] = GATE_END_RESET[k];
        1: e[k] = '0;
        2: e[k] = '1;
        3: begin
          acc += $urandom_range(0, 6);
          e[k] = END_W'(acc);
        end
        4: e[k] = END_W'($urandom_range(0, 40));
        default: e[k] = END_W'($urandom);
      endcase
    end
    return e;
  endfunction

  task automatic write_gates(end_array_t e);
    for (int k = 0; k < NUM_GATES; k++) begin
      cfg_we = 1'b1;
      cfg_index = gate_reg_e'(k);
      cfg_data = e[k];
      @(posedge clk);
      board.set_gate_end(k, e[k]);
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  task automatic send_sample(logic [SAMPLE_W-1:0] s, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sample = s;
    last_sample = last;
    do @(posedge clk); while (!in_ready);
    board.integrate_sample(s, last);
    @(negedge clk);
  endtask

  task automatic send_trace(int len);
    for (int i = 0; i < len; i++) begin
      send_sample(pick_sample(), i == len - 1);
    end
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (board.pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    idle_mode_e mode;
    int         sent;
    int         len;
    board = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = GATE0_END;
    cfg_data = '0;
    in_valid = 1'b0;
    sample = '0;
    last_sample = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_sample('1, 1'b1);
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample(16'h0001, 1'b1);
    settle();

    // out-of-order ends leave windows empty; samples past the last end drop
    write_gates({11'd9, 11'd8, 11'd7, 11'd6, 11'd4, 11'd4, 11'd1, 11'd2});
    for (int i = 0; i < 12; i++) begin
      send_sample(i[0] ? 16'hFFFF : (16'h5A5A ^ SAMPLE_W'(i)), i == 11);
    end
    settle();

    // trace runs past the index bound
    write_gates({11'd2047, 11'd1030, 11'd1024, 11'd1023,
                 11'd1000, 11'd600, 11'd300, 11'd100});
    send_trace(TRACE_BOUND + 16);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      mode = idle_mode_e'(p % 4);
      case (mode)
        IDLE_NONE: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        IDLE_SENDER: begin
          send_idle_pct = 86;
          stall_pct = 0;
        end
        IDLE_RECEIVER: begin
          send_idle_pct = 0;
          stall_pct = 86;
        end
        default: begin
          send_idle_pct = 29;
          stall_pct = 29;
        end
      endcase
      write_gates(pick_ends(p % 6));
      sent = 0;
      while (sent < PHASE_SAMPLES) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(25, 220) : $urandom_range(1, 16);
        send_trace(len);
        sent += len;
        if ($urandom_range(9) == 0) settle();
      end
      settle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/tgcs_pkg.sv
rtl/tgcs_cfg_regs.sv
rtl/tgcs_accum.sv
rtl/trace_gate_charge_sums_core.sv
tb/sv/tb_top.sv
